FILE: rtl/slxfr_pkg.sv
// ----------------------------------------------------------------------------
// Sync, length and XOR frame receiver package
// Shared types, register indexes, result codes and reset values.
// ----------------------------------------------------------------------------
package slxfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int MAX_FRAME        = 61;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SYNC_FIRST    = 3'd0,
        REG_SYNC_SECOND   = 3'd1,
        REG_MIN_LENGTH    = 3'd2,
        REG_MAX_LENGTH    = 3'd3,
        REG_TIMEOUT_TICKS = 3'd4
    } t_reg_index;

    typedef enum logic [1:0] {
        STATUS_NONE  = 2'd0,
        STATUS_GOOD  = 2'd1,
        STATUS_ERROR = 2'd2
    } t_status;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [7:0]  SYNC_FIRST_RST    = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST   = 8'h55;
    localparam logic [5:0]  MIN_LENGTH_RST    = 6'd2;
    localparam logic [5:0]  MAX_LENGTH_RST    = 6'd37;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10;

endpackage

FILE: rtl/slxfr_buf.sv
// ----------------------------------------------------------------------------
// Payload buffer
// Single write port and one registered read port for the frame payload.
// ----------------------------------------------------------------------------
module slxfr_buf #(
    parameter int DEPTH = slxfr_pkg::BUFFER_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/sync_length_xor_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// Sync, length and XOR frame receiver core
// Parses sync, length, payload and checksum bytes and replays good frames.
// ----------------------------------------------------------------------------
// The slave stream carries one item per received byte (tuser 0) or timer tick
// (tuser 1). Every item yields one result on the master stream, except the
// checksum byte of a good frame, which yields one result per payload byte with
// tlast on the final one. Payload bytes are stored in a small buffer as they
// arrive and are read back one at a time by the replay sequencer. A byte or
// tick that does not finish a good frame is parsed in the accept cycle and
// its result appears in the output register on the next cycle. A good frame
// is replayed through the buffer read port and its registered read data; the
// slave side is not ready meanwhile.
// The block takes a new item once the output register is empty or being taken,
// so a stalled receiver holds the slave side off.
// Configuration writes are taken in any cycle and should only be made while
// the block is idle. Reset restores the default register values, sets the
// parser idle and the timeout disarmed; no buffer clearing is needed.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_receiver_core #(
    parameter int BUFFER_DEPTH = slxfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,   // [7:0] rx_byte
    input  logic [0:0]                         i_s_tuser,   // [0] req_type
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [7:0] payload_byte, [13:8] payload_index, [19:14] frame_length, rest 0
    output logic [23:0]                        o_m_tdata,
    output logic [1:0]                         o_m_tuser,   // [1:0] status
    output logic                               o_m_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [slxfr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [slxfr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int AW        = $clog2(BUFFER_DEPTH);
    localparam int LEN_LIMIT = (slxfr_pkg::MAX_FRAME < BUFFER_DEPTH) ?
                               slxfr_pkg::MAX_FRAME : BUFFER_DEPTH;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_SYNC2 = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_CHECK = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        ST_READY = 3'b001,
        ST_FETCH = 3'b010,
        ST_LOAD  = 3'b100
    } t_state;

    logic [7:0]  r_sync_first, r_sync_second;
    logic [5:0]  r_min_len, r_max_len;
    logic [15:0] r_timeout;

    t_phase      r_phase, n_phase;
    t_state      r_state, n_state;
    logic [5:0]  r_exp_len, n_exp_len;
    logic [5:0]  r_count, n_count;
    logic [7:0]  r_csum, n_csum;
    logic [15:0] r_silence, n_silence;
    logic        r_armed, n_armed;
    logic [5:0]  r_dump_len, n_dump_len;
    logic [5:0]  r_rd_idx, n_rd_idx;

    logic                 r_out_valid, n_out_valid;
    slxfr_pkg::t_status   r_out_status, n_out_status;
    logic [7:0]           r_out_byte, n_out_byte;
    logic [5:0]           r_out_index, n_out_index;
    logic [5:0]           r_out_len, n_out_len;
    logic                 r_out_last, n_out_last;

    logic        w_out_free, w_in_acc, w_is_tick, w_wr_en, w_rd_en;
    logic [7:0]  w_b, w_rd_data;
    logic [15:0] w_sil_inc, w_limit;
    logic [5:0]  w_cnt_inc;
    logic        w_len_ok, w_dump_last;

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == ST_READY) && w_out_free;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_is_tick   = (i_s_tuser[0] == slxfr_pkg::REQ_TICK);
    assign w_b         = i_s_tdata;
    assign o_cfg_ready = 1'b1;

    assign w_sil_inc = (r_silence == 16'hFFFF) ? r_silence : r_silence + 16'd1;
    assign w_limit   = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
    assign w_cnt_inc = r_count + 6'd1;
    assign w_len_ok  = (w_b >= 8'd1) && (w_b >= {2'b00, r_min_len}) &&
                       (w_b <= {2'b00, r_max_len}) && (w_b <= 8'(LEN_LIMIT));
    assign w_dump_last = (r_rd_idx + 6'd1 == r_dump_len);

    assign w_wr_en = w_in_acc && !w_is_tick && (r_phase == PH_DATA);
    assign w_rd_en = (r_state == ST_FETCH);

    slxfr_buf #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(r_count)),
        .i_wr_data (w_b),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (AW'(r_rd_idx)),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= slxfr_pkg::SYNC_FIRST_RST;
            r_sync_second <= slxfr_pkg::SYNC_SECOND_RST;
            r_min_len     <= slxfr_pkg::MIN_LENGTH_RST;
            r_max_len     <= slxfr_pkg::MAX_LENGTH_RST;
            r_timeout     <= slxfr_pkg::TIMEOUT_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                slxfr_pkg::REG_SYNC_FIRST:    r_sync_first  <= i_cfg_wdata[7:0];
                slxfr_pkg::REG_SYNC_SECOND:   r_sync_second <= i_cfg_wdata[7:0];
                slxfr_pkg::REG_MIN_LENGTH:    r_min_len     <= i_cfg_wdata[5:0];
                slxfr_pkg::REG_MAX_LENGTH:    r_max_len     <= i_cfg_wdata[5:0];
                slxfr_pkg::REG_TIMEOUT_TICKS: r_timeout     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_state      = r_state;
        n_exp_len    = r_exp_len;
        n_count      = r_count;
        n_csum       = r_csum;
        n_silence    = r_silence;
        n_armed      = r_armed;
        n_dump_len   = r_dump_len;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_byte   = r_out_byte;
        n_out_index  = r_out_index;
        n_out_len    = r_out_len;
        n_out_last   = r_out_last;

        unique case (r_state)
            ST_READY: begin
                if (w_in_acc) begin
                    n_out_valid  = 1'b1;
                    n_out_status = slxfr_pkg::STATUS_NONE;
                    n_out_byte   = 8'd0;
                    n_out_index  = 6'd0;
                    n_out_len    = 6'd0;
                    n_out_last   = 1'b1;
                    if (w_is_tick) begin
                        if (r_armed) begin
                            n_silence = w_sil_inc;
                            if (w_sil_inc >= w_limit) begin
                                n_armed   = 1'b0;
                                n_silence = 16'd0;
                                n_phase   = PH_IDLE;
                                n_exp_len = 6'd0;
                                n_count   = 6'd0;
                                n_csum    = 8'd0;
                            end
                        end
                    end else begin
                        n_armed   = 1'b1;
                        n_silence = 16'd0;
                        unique case (r_phase)
                            PH_IDLE: begin
                                if (w_b == r_sync_first) begin
                                    n_phase = PH_SYNC2;
                                end
                            end
                            PH_SYNC2: begin
                                if (w_b == r_sync_second) begin
                                    n_phase = PH_LEN;
                                end else begin
                                    n_phase      = PH_IDLE;
                                    n_out_status = slxfr_pkg::STATUS_ERROR;
                                end
                            end
                            PH_LEN: begin
                                if (w_len_ok) begin
                                    n_exp_len = w_b[5:0];
                                    n_count   = 6'd0;
                                    n_csum    = w_b;
                                    n_phase   = PH_DATA;
                                end else begin
                                    n_phase      = PH_IDLE;
                                    n_exp_len    = 6'd0;
                                    n_count      = 6'd0;
                                    n_csum       = 8'd0;
                                    n_out_status = slxfr_pkg::STATUS_ERROR;
                                end
                            end
                            PH_DATA: begin
                                n_csum  = r_csum ^ w_b;
                                n_count = w_cnt_inc;
                                if (w_cnt_inc >= r_exp_len) begin
                                    n_phase = PH_CHECK;
                                end
                            end
                            PH_CHECK: begin
                                n_phase   = PH_IDLE;
                                n_exp_len = 6'd0;
                                n_count   = 6'd0;
                                n_csum    = 8'd0;
                                if (r_csum == w_b) begin
                                    n_out_valid = r_out_valid && !i_m_tready;
                                    n_dump_len  = r_exp_len;
                                    n_rd_idx    = 6'd0;
                                    n_state     = ST_FETCH;
                                end else begin
                                    n_out_status = slxfr_pkg::STATUS_ERROR;
                                end
                            end
                            default: begin
                                n_phase   = PH_IDLE;
                                n_exp_len = 6'd0;
                                n_count   = 6'd0;
                                n_csum    = 8'd0;
                            end
                        endcase
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = slxfr_pkg::STATUS_GOOD;
                    n_out_byte   = w_rd_data;
                    n_out_index  = r_rd_idx;
                    n_out_len    = r_dump_len;
                    n_out_last   = w_dump_last;
                    if (w_dump_last) begin
                        n_state = ST_READY;
                    end else begin
                        n_rd_idx = r_rd_idx + 6'd1;
                        n_state  = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_READY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_state     <= ST_READY;
            r_exp_len   <= 6'd0;
            r_count     <= 6'd0;
            r_csum      <= 8'd0;
            r_silence   <= 16'd0;
            r_armed     <= 1'b0;
            r_dump_len  <= 6'd0;
            r_rd_idx    <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_state     <= n_state;
            r_exp_len   <= n_exp_len;
            r_count     <= n_count;
            r_csum      <= n_csum;
            r_silence   <= n_silence;
            r_armed     <= n_armed;
            r_dump_len  <= n_dump_len;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_byte   <= n_out_byte;
        r_out_index  <= n_out_index;
        r_out_len    <= n_out_len;
        r_out_last   <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {4'd0, r_out_len, r_out_index, r_out_byte};
    assign o_m_tlast  = r_out_last;

    a_good_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == slxfr_pkg::STATUS_GOOD && r_out_last) |->
        (r_out_index + 6'd1 == r_out_len))
        else $error("last good byte does not close the frame");

    a_other_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != slxfr_pkg::STATUS_GOOD) |->
        (r_out_last && r_out_byte == 8'd0 && r_out_len == 6'd0))
        else $error("non-payload result is not a single cleared item");

    a_replay_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_READY) |-> (r_rd_idx < r_dump_len && r_phase == PH_IDLE))
        else $error("replay index out of range or parser busy");

    a_byte_arms_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_is_tick) |=> (r_armed && r_silence == 16'd0))
        else $error("received byte did not restart the timeout");

    a_no_accept_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH || r_state == ST_LOAD) |-> !o_s_tready)
        else $error("input taken during frame replay");

endmodule
